// ===== rtl/core/touch_edge_suppression_filter_core_defines.svh =====
// Assertion macros for the touch edge suppression filter core.
// Used by the controller and the top level; no other dependencies.
`ifndef TOUCH_EDGE_SUPPRESSION_FILTER_CORE_DEFINES_SVH
`define TOUCH_EDGE_SUPPRESSION_FILTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// implication checked every clock outside reset
`define TESF_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication
`define TESF_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define TESF_ASSERT_IMP(lbl, clk, rst, a, c)
`define TESF_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

// ===== rtl/core/tesf_pkg.sv =====
// Shared types and constants for the touch edge suppression filter.
// No dependencies.
`default_nettype none
package tesf_pkg;
   localparam int CoordW = 16;
   localparam int FingerW = 4;
   localparam int TravelW = 8;
   localparam int CsrIdxW = 3;
   localparam int HistDepth = 2;

   localparam logic [CsrIdxW-1:0] CSR_EDGE_WIDTH    = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_EDGE_HEIGHT   = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_MIN_TRAVEL    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_SCREEN_WIDTH  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_SCREEN_HEIGHT = 3'd4;

   localparam logic OP_TOUCH = 1'b0;
   localparam logic OP_LIFT  = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [FingerW-1:0]  finger;
      logic [CoordW-1:0]   pos_x;
      logic [CoordW-1:0]   pos_y;
      logic [CoordW-1:0]   major_axis;
      logic [CoordW-1:0]   touch_pressure;
   } req_word_type;

   typedef struct packed {
      logic                suppressed;
      logic [FingerW-1:0]  out_finger;
      logic [CoordW-1:0]   out_x;
      logic [CoordW-1:0]   out_y;
      logic [CoordW-1:0]   out_major;
      logic [CoordW-1:0]   out_pressure;
   } rsp_word_type;

   typedef struct packed {
      logic [CsrIdxW-1:0] index;
      logic [CoordW-1:0]  data;
   } csr_word_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request word
      logic rd_front;   // read oldest entry and slot state
      logic rd_rear;    // read newest entry
      logic eval;       // compute zone, direction, deltas
      logic div_start;  // start slope divisions
      logic decide;     // evaluate release decision, write state, form result
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_lift;
      logic need_check; // valid finger, not released
      logic full;       // history holds two entries
      logic need_div;   // zone point with passing direction test
      logic div_done;
   } ctl_sts_type;
endpackage
`default_nettype wire

// ===== rtl/core/tesf_if.sv =====
// Valid/ready channel interface carrying one payload word.
// Payload type is a parameter; used with tesf_pkg word types.
`default_nettype none
interface tesf_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tesf_div.sv =====
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing but its ports.
`default_nettype none
module tesf_div #(
   parameter int W = 18
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quotient
);
   localparam int CntW = $clog2(W + 1);
   logic [W-1:0]    rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic            neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [W:0]      trial;

   // restoring step on magnitudes
   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff; neg_in = neg_ff;
      busy_in = busy_ff; cnt_in = cnt_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[W-1]} - {1'b0, den_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend[W-1] ? (~dividend + 1'b1) : dividend;
         den_in = divisor[W-1] ? (~divisor + 1'b1) : divisor;
         neg_in = dividend[W-1] ^ divisor[W-1];
         busy_in = 1'b1;
         cnt_in = CntW'(W);
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
endmodule
`default_nettype wire

// ===== rtl/core/tesf_datapath.sv =====
// Datapath: config registers, per-finger history memory, zone and slope tests.
// Depends on tesf_pkg, tesf_div.
`default_nettype none
module tesf_datapath #(
   parameter int FINGERS = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire tesf_pkg::csr_word_type csr_word,
   input  wire tesf_pkg::req_word_type req_word,
   input  wire tesf_pkg::ctl_cmd_type  cmd,
   output tesf_pkg::ctl_sts_type       sts,
   output tesf_pkg::rsp_word_type      rsp_word
);
   localparam int FIdxW = (FINGERS > 1) ? $clog2(FINGERS) : 1;
   localparam int EntW  = $clog2(FINGERS * tesf_pkg::HistDepth);
   localparam int DW    = tesf_pkg::CoordW + 2;

   logic [tesf_pkg::CoordW-1:0]  ew_ff, eh_ff, sw_ff, sh_ff;
   logic [tesf_pkg::TravelW-1:0] mt_ff;

   // history memory: {x, y, major, pressure}
   logic [4*tesf_pkg::CoordW-1:0] hist_mem [FINGERS*tesf_pkg::HistDepth];
   logic [4*tesf_pkg::CoordW-1:0] rd_ff;
   logic [4*tesf_pkg::CoordW-1:0] front_ff;

   logic [FINGERS-1:0] hfront_ff, released_ff;
   logic [1:0]         hcount_ff [FINGERS];

   tesf_pkg::req_word_type req_ff;
   logic       valid_f;
   logic [FIdxW-1:0] fidx;
   logic       sf_front_ff, sf_rel_ff;
   logic [1:0] sf_count_ff;
   logic [EntW-1:0] rd_addr, wr_addr;
   logic       zone_ff, dir_ff;
   logic signed [DW-1:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   logic [DW-1:0] q1, q2;
   logic d1_done, d2_done, d_done_ff;
   logic       match;
   tesf_pkg::rsp_word_type rsp_ff;

   assign valid_f = ({1'b0, req_ff.finger} < 5'(FINGERS));
   assign fidx = FIdxW'(req_ff.finger);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ew_ff <= '0; eh_ff <= '0; mt_ff <= '0; sw_ff <= '1; sh_ff <= '1;
      end else if (csr_we) begin
         case (csr_word.index)
            tesf_pkg::CSR_EDGE_WIDTH:    ew_ff <= csr_word.data;
            tesf_pkg::CSR_EDGE_HEIGHT:   eh_ff <= csr_word.data;
            tesf_pkg::CSR_MIN_TRAVEL:    mt_ff <= csr_word.data[tesf_pkg::TravelW-1:0];
            tesf_pkg::CSR_SCREEN_WIDTH:  sw_ff <= csr_word.data;
            tesf_pkg::CSR_SCREEN_HEIGHT: sh_ff <= csr_word.data;
            default: ;
         endcase
      end
   end

   // request capture and slot state snapshot
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_word;
      if (cmd.rd_front) begin
         sf_front_ff <= hfront_ff[fidx];
         sf_count_ff <= hcount_ff[fidx];
         sf_rel_ff   <= released_ff[fidx];
      end
   end

   assign rd_addr = cmd.rd_front ? EntW'({fidx, hfront_ff[fidx]})
                                 : EntW'({fidx, ~sf_front_ff});
   assign wr_addr = (sf_count_ff == 2'd2) ? EntW'({fidx, sf_front_ff})
                  : EntW'({fidx, sf_front_ff ^ sf_count_ff[0]});

   // memory read (registered) and write
   always_ff @(posedge clock) begin
      rd_ff <= hist_mem[rd_addr];
      if (cmd.decide && valid_f && req_ff.operation == tesf_pkg::OP_TOUCH && !sf_rel_ff
          && zone_ff && !match)
         hist_mem[wr_addr] <= {req_ff.pos_x, req_ff.pos_y, req_ff.major_axis,
                               req_ff.touch_pressure};
   end

   // oldest entry kept; newest stays in rd_ff through evaluation
   always_ff @(posedge clock) begin
      if (cmd.rd_rear) front_ff <= rd_ff;
   end

   // zone, direction and deltas
   logic signed [DW-1:0] x_s, y_s, ew_s, eh_s, sw_s, sh_s, lim_s;
   logic signed [DW-1:0] fx_s, fy_s, rx_s, ry_s, dx3, dy3, dx1, dy1;
   always_comb begin
      x_s  = DW'(req_ff.pos_x);  y_s  = DW'(req_ff.pos_y);
      ew_s = DW'(ew_ff); eh_s = DW'(eh_ff); sw_s = DW'(sw_ff); sh_s = DW'(sh_ff);
      lim_s = DW'(mt_ff);
      fx_s = DW'(front_ff[4*tesf_pkg::CoordW-1 -: tesf_pkg::CoordW]);
      fy_s = DW'(front_ff[3*tesf_pkg::CoordW-1 -: tesf_pkg::CoordW]);
      rx_s = DW'(rd_ff[4*tesf_pkg::CoordW-1 -: tesf_pkg::CoordW]);
      ry_s = DW'(rd_ff[3*tesf_pkg::CoordW-1 -: tesf_pkg::CoordW]);
      dx1 = rx_s - fx_s; dy1 = ry_s - fy_s;
      dx3 = x_s - rx_s;  dy3 = y_s - ry_s;
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         zone_ff <= ((ew_s > x_s) || (sw_s - ew_s < x_s)) && (sh_s - eh_s < y_s);
         dir_ff  <= (sf_count_ff == 2'd2) &&
                    ((((dx1 > lim_s) || (dy1 > lim_s)) && ((dx3 > lim_s) || (dy3 > lim_s)))
                  || (((dx1 < -lim_s) || (dy1 < -lim_s)) && ((dx3 < -lim_s) || (dy3 < -lim_s))));
         dx1_ff <= dx1; dy1_ff <= dy1;
         dx2_ff <= x_s - fx_s; dy2_ff <= y_s - fy_s;
      end
   end

   tesf_div #(.W(DW)) u_div1 (.clock, .reset, .start(cmd.div_start), .dividend(dy1_ff),
      .divisor(dx1_ff), .done(d1_done), .quotient(q1));
   tesf_div #(.W(DW)) u_div2 (.clock, .reset, .start(cmd.div_start), .dividend(dy2_ff),
      .divisor(dx2_ff), .done(d2_done), .quotient(q2));

   always_ff @(posedge clock) begin
      if (reset) d_done_ff <= 1'b0;
      else d_done_ff <= d1_done & d2_done;
   end

   // slope compare with zero-dx special cases
   always_comb begin
      if (!dir_ff) match = 1'b0;
      else if (dx1_ff == '0 && dx2_ff == '0) match = 1'b1;
      else if (dx1_ff == '0) match = (q2 == '0);
      else if (dx2_ff == '0) match = (q1 == '0);
      else match = (q1 == q2);
   end

   // slot state update and result
   always_ff @(posedge clock) begin
      if (reset) begin
         hfront_ff <= '0; released_ff <= '0;
         for (int i = 0; i < FINGERS; i++) hcount_ff[i] <= '0;
      end else if (cmd.decide && valid_f) begin
         if (req_ff.operation == tesf_pkg::OP_LIFT) begin
            hfront_ff[fidx] <= 1'b0; hcount_ff[fidx] <= '0; released_ff[fidx] <= 1'b0;
         end else if (!sf_rel_ff) begin
            if (zone_ff && !match) begin
               if (sf_count_ff == 2'd2) hfront_ff[fidx] <= ~sf_front_ff;
               else hcount_ff[fidx] <= sf_count_ff + 2'd1;
            end else begin
               hfront_ff[fidx] <= 1'b0; hcount_ff[fidx] <= '0; released_ff[fidx] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rsp_ff.out_finger <= req_ff.finger;
         if (valid_f && !sf_rel_ff && zone_ff && !match) begin
            rsp_ff.suppressed <= 1'b1;
            rsp_ff.out_x <= '0; rsp_ff.out_y <= '0;
            rsp_ff.out_major <= '0; rsp_ff.out_pressure <= '0;
         end else if (valid_f && !sf_rel_ff && sf_count_ff != 2'd0) begin
            rsp_ff.suppressed <= 1'b0;
            {rsp_ff.out_x, rsp_ff.out_y, rsp_ff.out_major, rsp_ff.out_pressure} <= front_ff;
         end else begin
            rsp_ff.suppressed <= 1'b0;
            rsp_ff.out_x <= req_ff.pos_x; rsp_ff.out_y <= req_ff.pos_y;
            rsp_ff.out_major <= req_ff.major_axis;
            rsp_ff.out_pressure <= req_ff.touch_pressure;
         end
      end
   end

   assign rsp_word = rsp_ff;
   assign sts.is_lift    = (req_ff.operation == tesf_pkg::OP_LIFT);
   assign sts.need_check = valid_f && !sf_rel_ff;
   assign sts.full       = (sf_count_ff == 2'd2);
   assign sts.need_div   = zone_ff && dir_ff;
   assign sts.div_done   = d_done_ff;
endmodule
`default_nettype wire

// ===== rtl/core/tesf_ctrl.sv =====
// Controller state machine: sequences reads, evaluation, division and result.
// Depends on tesf_pkg and the assertion macro header.
`include "touch_edge_suppression_filter_core_defines.svh"
`default_nettype none
module tesf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire tesf_pkg::ctl_sts_type sts,
   output tesf_pkg::ctl_cmd_type      cmd
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RDF   = 3'd1;
   localparam logic [2:0] S_RDR   = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_CHK   = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_DEC   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rspv_ff, rspv_in;
   logic       accept;

   // result register frees when taken; new word waits until it is free
   assign req_ready = (state_ff == S_IDLE) && (!rspv_ff || rsp_ready);
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      rspv_in  = rspv_ff && !rsp_ready;
      cmd = '0;
      cmd.load = accept;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_RDF;
         S_RDF: begin
            cmd.rd_front = 1'b1;
            state_in = S_RDR;
         end
         S_RDR: begin
            cmd.rd_rear = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (sts.need_check && !sts.is_lift && sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else state_in = S_DEC;
         end
         S_DIV: if (sts.div_done) state_in = S_DEC;
         S_DEC: begin
            cmd.decide = 1'b1;
            rspv_in = !sts.is_lift;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rspv_ff  <= rspv_in;
      end
   end

   assign rsp_valid = rspv_ff;

   `TESF_ASSERT_IMP(a_accept_idle, clock, reset, accept, state_ff == S_IDLE)
   `TESF_ASSERT_NXT(a_lift_no_rsp, clock, reset, state_ff == S_DEC && sts.is_lift && !rspv_ff,
      !rspv_ff)
   `TESF_ASSERT_IMP(a_div_only_full, clock, reset, cmd.div_start, sts.full)
endmodule
`default_nettype wire

// ===== rtl/core/touch_edge_suppression_filter_core.sv =====
// Top level of the touch edge suppression filter core.
// Depends on tesf_pkg, tesf_if, tesf_ctrl, tesf_datapath, tesf_div.
//
// channel | dir | handshake              | word
// req     | in  | req_valid / req_ready  | operation, finger, pos, major, pressure
// rsp     | out | rsp_valid / rsp_ready  | suppressed, finger, x, y, major, pressure
// csr     | in  | csr_valid / csr_ready  | register index, data
//
// A zone point with full history that needs the slope test runs two serial
// dividers side by side. Reset is synchronous and clears all slot state at
// once. A pending result holds in its output register; the next word is
// accepted as soon as that register is free.
`include "touch_edge_suppression_filter_core_defines.svh"
`default_nettype none
module touch_edge_suppression_filter_core #(
   parameter int FINGERS = 10
) (
   input  wire logic clock,
   input  wire logic reset,
   tesf_if.sink      req,
   tesf_if.source    rsp,
   tesf_if.sink      csr
);
   tesf_pkg::ctl_cmd_type cmd;
   tesf_pkg::ctl_sts_type sts;

   assign csr.ready = 1'b1;

   tesf_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts, .cmd
   );

   tesf_datapath #(.FINGERS(FINGERS)) u_dp (
      .clock, .reset,
      .csr_we(csr.valid), .csr_word(csr.word),
      .req_word(req.word), .cmd, .sts, .rsp_word(rsp.word)
   );

   `TESF_ASSERT_NXT(a_rsp_stall_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `TESF_ASSERT_NXT(a_no_accept_while_busy, clock, reset, req.valid && req.ready, !req.ready)
   `TESF_ASSERT_IMP(a_csr_always_ready, clock, reset, csr.valid, csr.ready)
endmodule
`default_nettype wire

// ===== verif/tesf_filter_checker.sv =====
// Checker for the touch edge suppression filter: watches the req, rsp and csr
// channels, predicts each rsp word and compares it field by field.
// Depends on tesf_pkg.
`timescale 1ns / 100ps
module tesf_filter_checker
   import tesf_pkg::*;
#(
   parameter int FINGERS = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_word,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  csr_word_type csr_word,
   output int           fail_count,
   output int           pending
);
   // shadow configuration
   logic [15:0] edge_w, edge_h, scr_w, scr_h;
   logic [7:0]  travel;

   // shadow per-finger history
   logic [15:0] hist_x [FINGERS*2];
   logic [15:0] hist_y [FINGERS*2];
   logic [15:0] hist_m [FINGERS*2];
   logic [15:0] hist_p [FINGERS*2];
   bit          hist_front [FINGERS];
   bit [1:0]    hist_count [FINGERS];
   bit          released   [FINGERS];

   rsp_word_type expected_words[$];

   assign pending = expected_words.size();

   function automatic bit in_grip_zone(int x, int y);
      int ew;
      bit side;
      ew = int'(edge_w);
      side = (ew > x) || (int'(scr_w) - ew < x);
      return side && (int'(scr_h) - int'(edge_h) < y);
   endfunction

   // zero dx: both zero matches, otherwise the other slope must be zero
   function automatic bit slopes_agree(int dx1, int dy1, int dx2, int dy2);
      if (dx1 == 0 && dx2 == 0) return 1'b1;
      if (dx1 == 0) return (dy2 / dx2) == 0;
      if (dx2 == 0) return (dy1 / dx1) == 0;
      return (dy1 / dx1) == (dy2 / dx2);
   endfunction

   function automatic bit swipe_releases(int f, int x, int y);
      int fr, rr, lim, dx1, dy1, dx2, dy2, dx3, dy3;
      bit pos, neg;
      if (hist_count[f] != 2) return 1'b0;
      fr  = f * 2 + hist_front[f];
      rr  = f * 2 + (hist_front[f] ^ 1'b1);
      lim = int'(travel);
      dx1 = int'(hist_x[rr]) - int'(hist_x[fr]);
      dy1 = int'(hist_y[rr]) - int'(hist_y[fr]);
      dx2 = x - int'(hist_x[fr]);
      dy2 = y - int'(hist_y[fr]);
      dx3 = x - int'(hist_x[rr]);
      dy3 = y - int'(hist_y[rr]);
      pos = (dx1 > lim || dy1 > lim) && (dx3 > lim || dy3 > lim);
      neg = (dx1 < -lim || dy1 < -lim) && (dx3 < -lim || dy3 < -lim);
      if (!(pos || neg)) return 1'b0;
      return slopes_agree(dx1, dy1, dx2, dy2);
   endfunction

   task automatic predict_filter(input req_word_type w);
      int f, x, y, fr, slot;
      rsp_word_type r;
      f = int'(w.finger);
      x = int'(w.pos_x);
      y = int'(w.pos_y);
      // lift clears the slot, no word out
      if (w.operation == OP_LIFT) begin
         if (f < FINGERS) begin
            hist_front[f] = 1'b0;
            hist_count[f] = 2'd0;
            released[f]   = 1'b0;
         end
         return;
      end
      r.suppressed   = 1'b0;
      r.out_finger   = w.finger;
      r.out_x        = w.pos_x;
      r.out_y        = w.pos_y;
      r.out_major    = w.major_axis;
      r.out_pressure = w.touch_pressure;
      if (f < FINGERS && !released[f]) begin
         if (in_grip_zone(x, y) && !swipe_releases(f, x, y)) begin
            // hold the point; a full history drops its oldest entry
            if (hist_count[f] == 2) begin
               hist_front[f] = hist_front[f] ^ 1'b1;
               hist_count[f] = 2'd1;
            end
            slot = f * 2 + ((hist_front[f] + hist_count[f]) & 1);
            hist_x[slot] = w.pos_x;
            hist_y[slot] = w.pos_y;
            hist_m[slot] = w.major_axis;
            hist_p[slot] = w.touch_pressure;
            hist_count[f] = hist_count[f] + 2'd1;
            r = '0;
            r.suppressed = 1'b1;
            r.out_finger = w.finger;
         end else begin
            // first pass-through reports the oldest held point
            if (hist_count[f] != 0) begin
               fr = f * 2 + hist_front[f];
               r.out_x        = hist_x[fr];
               r.out_y        = hist_y[fr];
               r.out_major    = hist_m[fr];
               r.out_pressure = hist_p[fr];
            end
            hist_front[f] = 1'b0;
            hist_count[f] = 2'd0;
            released[f]   = 1'b1;
         end
      end
      expected_words.push_back(r);
   endtask

   task automatic compare_word(input rsp_word_type got);
      rsp_word_type exp_w;
      if (expected_words.size() == 0) begin
         $error("rsp word with nothing expected: %h", got);
         fail_count++;
         return;
      end
      exp_w = expected_words.pop_front();
      if (got.suppressed !== exp_w.suppressed) begin
         $error("suppressed expected %0d got %0d", exp_w.suppressed, got.suppressed);
         fail_count++;
      end
      if (got.out_finger !== exp_w.out_finger) begin
         $error("out_finger expected %0d got %0d", exp_w.out_finger, got.out_finger);
         fail_count++;
      end
      if (got.out_x !== exp_w.out_x) begin
         $error("out_x expected %0d got %0d", exp_w.out_x, got.out_x);
         fail_count++;
      end
      if (got.out_y !== exp_w.out_y) begin
         $error("out_y expected %0d got %0d", exp_w.out_y, got.out_y);
         fail_count++;
      end
      if (got.out_major !== exp_w.out_major) begin
         $error("out_major expected %0d got %0d", exp_w.out_major, got.out_major);
         fail_count++;
      end
      if (got.out_pressure !== exp_w.out_pressure) begin
         $error("out_pressure expected %0d got %0d", exp_w.out_pressure, got.out_pressure);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   // sample all three channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         edge_w = 16'd0;
         edge_h = 16'd0;
         travel = 8'd0;
         scr_w  = 16'hFFFF;
         scr_h  = 16'hFFFF;
         for (int i = 0; i < FINGERS; i++) begin
            hist_front[i] = 1'b0;
            hist_count[i] = 2'd0;
            released[i]   = 1'b0;
         end
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_word.index)
               CSR_EDGE_WIDTH:    edge_w = csr_word.data;
               CSR_EDGE_HEIGHT:   edge_h = csr_word.data;
               CSR_MIN_TRAVEL:    travel = csr_word.data[7:0];
               CSR_SCREEN_WIDTH:  scr_w  = csr_word.data;
               CSR_SCREEN_HEIGHT: scr_h  = csr_word.data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_filter(req_word);
         if (rsp_valid && rsp_ready) compare_word(rsp_word);
      end
   end
endmodule

// ===== verif/tb_touch_edge_suppression_filter_core.sv =====
// Testbench top for the touch edge suppression filter core: drives touch and
// lift words and register writes, and gives the verdict.
// Depends on tesf_pkg, tesf_if, the core and tesf_filter_checker.
`timescale 1ns / 100ps
module tb_touch_edge_suppression_filter_core;
   import tesf_pkg::*;

   localparam int FINGERS       = 10;
   localparam int DRAIN_CYCLES  = 40;
   localparam int WATCHDOG      = 3000;
   localparam int TOTAL_ITEMS   = 1450;
   localparam int PHASE_ITEMS   = 160;
   localparam logic [CsrIdxW-1:0] CSR_UNUSED = 3'd7;

   logic clock;
   logic reset;
   int   fail_count, pending, idle_cycles, items_sent;
   int   ready_left;
   bit   no_gaps;

   // stimulus copy of the configuration, used to aim points at the zone
   int cfg_ew, cfg_eh, cfg_sw, cfg_sh;

   tesf_if #(.word_type(req_word_type)) req_ch ();
   tesf_if #(.word_type(rsp_word_type)) rsp_ch ();
   tesf_if #(.word_type(csr_word_type)) csr_ch ();

   touch_edge_suppression_filter_core #(.FINGERS(FINGERS)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   tesf_filter_checker #(.FINGERS(FINGERS)) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_word   (req_ch.word),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_word   (rsp_ch.word),
      .csr_valid  (csr_ch.valid),
      .csr_ready  (csr_ch.ready),
      .csr_word   (csr_ch.word),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // rsp backpressure: ready bursts, short stalls, rare long stalls
   always @(posedge clock) begin
      int mode;
      if (ready_left > 0) begin
         ready_left <= ready_left - 1;
      end else begin
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            rsp_ch.ready <= 1'b1;
            ready_left <= $urandom_range(1, 20);
         end else if (mode < 9) begin
            rsp_ch.ready <= 1'b0;
            ready_left <= $urandom_range(1, 4);
         end else begin
            rsp_ch.ready <= 1'b0;
            ready_left <= $urandom_range(20, 120);
         end
      end
   end

   // cycles with no word moving on any channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic int clamp16(int v);
      if (v < 0) return 0;
      if (v > 65535) return 65535;
      return v;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(30, 100);
   endfunction

   task automatic send_req(input req_word_type w);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.word  <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_touch(input int f, input int x, input int y,
                             input int m, input int p);
      req_word_type w;
      w.operation      = OP_TOUCH;
      w.finger         = f[3:0];
      w.pos_x          = 16'(clamp16(x));
      w.pos_y          = 16'(clamp16(y));
      w.major_axis     = m[15:0];
      w.touch_pressure = p[15:0];
      send_req(w);
   endtask

   task automatic send_lift(input int f);
      req_word_type w;
      w = '0;
      w.operation = OP_LIFT;
      w.finger    = f[3:0];
      send_req(w);
   endtask

   // hold off until every expected word is back and lifts are done
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input int data);
      csr_ch.valid <= 1'b1;
      csr_ch.word  <= '{index: idx, data: data[15:0]};
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_EDGE_WIDTH:    cfg_ew = data & 16'hFFFF;
         CSR_EDGE_HEIGHT:   cfg_eh = data & 16'hFFFF;
         CSR_SCREEN_WIDTH:  cfg_sw = data & 16'hFFFF;
         CSR_SCREEN_HEIGHT: cfg_sh = data & 16'hFFFF;
         default: ;
      endcase
   endtask

   task automatic set_config(input int ew, input int eh, input int mt,
                             input int sw, input int sh);
      write_csr(CSR_EDGE_WIDTH, ew);
      write_csr(CSR_EDGE_HEIGHT, eh);
      write_csr(CSR_MIN_TRAVEL, mt);
      write_csr(CSR_SCREEN_WIDTH, sw);
      write_csr(CSR_SCREEN_HEIGHT, sh);
   endtask

   // swipe starting inside the zone, with random step and some jitter
   task automatic send_swipe();
      int f, x, y, dx, dy, n, lo;
      f = ($urandom_range(0, 19) == 0) ? $urandom_range(FINGERS, 15)
                                       : $urandom_range(0, FINGERS - 1);
      if ($urandom_range(0, 1) == 0) x = $urandom_range(0, (cfg_ew > 0) ? cfg_ew - 1 : 0);
      else begin
         lo = clamp16(cfg_sw - cfg_ew + 1);
         x  = $urandom_range(lo, 65535);
      end
      lo = clamp16(cfg_sh - cfg_eh + 1);
      y  = $urandom_range(lo, 65535);
      dx = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(0, 80)) - 40;
      dy = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(0, 80)) - 40;
      n  = $urandom_range(1, 5);
      for (int k = 0; k < n; k++) begin
         send_touch(f, x, y, $urandom_range(0, 65535), $urandom_range(0, 65535));
         x = x + dx + (($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 6)) - 3 : 0);
         y = y + dy + (($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 6)) - 3 : 0);
      end
      if ($urandom_range(0, 9) < 7) send_lift(f);
   endtask

   // fully random word, any slot and operation
   task automatic send_noise();
      req_word_type w;
      w.operation      = 1'($urandom_range(0, 1));
      w.finger         = 4'($urandom_range(0, 15));
      w.pos_x          = 16'($urandom);
      w.pos_y          = 16'($urandom);
      w.major_axis     = 16'($urandom);
      w.touch_pressure = 16'($urandom);
      send_req(w);
   endtask

   initial begin
      int phase, phase_start, sw, sh;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.word   = '0;
      csr_ch.valid  = 1'b0;
      csr_ch.word   = '0;
      rsp_ch.ready  = 1'b0;
      ready_left    = 0;
      idle_cycles   = 0;
      items_sent    = 0;
      no_gaps       = 1'b0;
      cfg_ew = 0; cfg_eh = 0; cfg_sw = 65535; cfg_sh = 65535;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zone at the lower corners of a 4000 x 3000 panel
      set_config(1000, 1000, 5, 4000, 3000);
      write_csr(CSR_UNUSED, 16'hFFFF);
      // straight swipe released on the third point
      send_touch(0, 100, 2500, 11, 21);
      send_touch(0, 110, 2510, 12, 22);
      send_touch(0, 120, 2520, 13, 23);
      send_touch(0, 3990, 2990, 14, 24);
      send_lift(0);
      // both dx zero
      send_touch(1, 100, 2500, 1, 1);
      send_touch(1, 100, 2510, 2, 2);
      send_touch(1, 100, 2520, 3, 3);
      // only first dx zero
      send_touch(2, 200, 2500, 4, 4);
      send_touch(2, 200, 2510, 5, 5);
      send_touch(2, 230, 2511, 6, 6);
      // only second dx zero
      send_touch(3, 300, 2500, 7, 7);
      send_touch(3, 320, 2501, 8, 8);
      send_touch(3, 300, 2520, 9, 9);
      // right edge, no movement: full history drops the oldest
      send_touch(4, 3500, 2900, 65535, 65535);
      send_touch(4, 3500, 2900, 0, 0);
      send_touch(4, 3500, 2900, 1, 65535);
      send_touch(4, 0, 65535, 65535, 0);
      send_touch(4, 2000, 100, 2, 2);
      // slot beyond the finger count, and field extremes outside the zone
      send_touch(15, 0, 65535, 65535, 65535);
      send_lift(12);
      send_touch(9, 65535, 0, 0, 0);
      send_lift(9);
      send_lift(4);

      // random phases, the extremes of the registers among them
      phase = 0;
      while (items_sent < TOTAL_ITEMS) begin
         drain();
         phase++;
         case (phase % 8)
            1: set_config(65535, 65535, 255, 65535, 65535);
            2: set_config(0, 0, 0, 0, 0);
            3: set_config(0, 0, 0, 65535, 65535);
            4: set_config(65535, 0, 0, 0, 65535);
            default: begin
               sw = $urandom_range(100, 65535);
               sh = $urandom_range(100, 65535);
               set_config($urandom_range(0, sw / 2), $urandom_range(0, sh),
                          ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 40), sw, sh);
            end
         endcase
         no_gaps = (phase % 3 == 0);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 8) send_swipe();
            else send_noise();
            // sender waits for the pipe to empty now and then
            if ($urandom_range(0, 199) == 0) drain();
         end
      end

      drain();
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
